// ----- sv/mstt_pkg.sv -----
// ----------------------------------------------------------------------------
// mstt_pkg
// Shared types, character codes, tables and helpers of the melody parser.
// ----------------------------------------------------------------------------
package mstt_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } in_item_t;

    typedef struct packed {
        logic [12:0] frequency_hz;
        logic [12:0] duration_ms;
        logic        end_of_melody;
        logic        no_notes;
    } out_item_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_TEMPO      = 3'd0;
    localparam logic [2:0] CFG_LENGTH     = 3'd1;
    localparam logic [2:0] CFG_ARTIC      = 3'd2;
    localparam logic [2:0] CFG_OCTAVE     = 3'd3;
    localparam logic [2:0] CFG_TRANSPOSE  = 3'd4;

    // Articulation codes
    localparam logic [1:0] ART_NORMAL   = 2'd0;
    localparam logic [1:0] ART_LEGATO   = 2'd1;
    localparam logic [1:0] ART_STACCATO = 2'd2;
    localparam logic [1:0] ART_MUTE     = 2'd3;

    // Character codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_O      = 8'h4F;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_U      = 8'h55;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    localparam logic [7:0]  TEMPO_MIN    = 8'd32;
    localparam logic [15:0] MS_PER_MIN   = 16'd60000;
    localparam logic [10:0] TB_RESET     = 11'd500;
    localparam logic [6:0]  PITCH_LAST   = 7'd107;

    localparam logic [12:0] PITCH_HZ [108] = '{
        13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0,
        13'd31, 13'd35, 13'd37, 13'd39, 13'd41, 13'd44, 13'd46, 13'd49, 13'd52, 13'd55,
        13'd58, 13'd62,
        13'd65, 13'd69, 13'd73, 13'd78, 13'd82, 13'd87, 13'd93, 13'd98, 13'd104, 13'd110,
        13'd117, 13'd123,
        13'd131, 13'd139, 13'd147, 13'd156, 13'd165, 13'd175, 13'd185, 13'd196, 13'd208,
        13'd220, 13'd233, 13'd247,
        13'd262, 13'd277, 13'd294, 13'd311, 13'd330, 13'd349, 13'd370, 13'd392, 13'd415,
        13'd440, 13'd466, 13'd494,
        13'd523, 13'd554, 13'd587, 13'd622, 13'd659, 13'd698, 13'd740, 13'd784, 13'd831,
        13'd880, 13'd932, 13'd988,
        13'd1047, 13'd1109, 13'd1175, 13'd1245, 13'd1319, 13'd1397, 13'd1480, 13'd1568,
        13'd1661, 13'd1760, 13'd1865, 13'd1976,
        13'd2093, 13'd2217, 13'd2349, 13'd2489, 13'd2637, 13'd2794, 13'd2960, 13'd3136,
        13'd3322, 13'd3520, 13'd3729, 13'd3951,
        13'd4186, 13'd4435, 13'd4699, 13'd4978, 13'd5274, 13'd5588, 13'd5920, 13'd6272,
        13'd6645, 13'd7040, 13'd7459, 13'd7902
    };

    localparam logic [3:0] LETTER_SEMI [7] = '{4'd9, 4'd11, 4'd0, 4'd2, 4'd4, 4'd5, 4'd7};

    typedef struct packed {
        logic [2:0] num;
        logic [4:0] den;
    } ratio_t;

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= CH_0) && (ch <= CH_9);
    endfunction

    function automatic ratio_t length_ratio(input logic [14:0] code);
        ratio_t r;
        r = '{num: 3'd1, den: 5'd1};
        unique case (code)
            15'd1:   r.num = 3'd4;
            15'd2:   r.num = 3'd2;
            15'd4:   ;
            15'd8:   r.den = 5'd2;
            15'd16:  r.den = 5'd4;
            15'd32:  r.den = 5'd8;
            15'd64:  r.den = 5'd16;
            15'd3:   r.num = 3'd3;
            15'd6:   begin r.num = 3'd3; r.den = 5'd2; end
            15'd12:  begin r.num = 3'd3; r.den = 5'd4; end
            15'd24:  begin r.num = 3'd3; r.den = 5'd8; end
            15'd48:  begin r.num = 3'd3; r.den = 5'd16; end
            15'd34:  begin r.num = 3'd2; r.den = 5'd3; end
            15'd38:  r.den = 5'd3;
            15'd316: r.den = 5'd6;
            15'd332: r.den = 5'd12;
            default: r.num = 3'd0;
        endcase
        return r;
    endfunction

    typedef enum logic [3:0] {
        ST_IDLE, ST_RESTORE, ST_PARSE1, ST_PARSE2, ST_DISPATCH,
        ST_TB_GO, ST_TB_WAIT, ST_D1_GO, ST_D1_WAIT, ST_EMIT1,
        ST_D2_GO, ST_D2_WAIT, ST_EMIT2, ST_SHIFT, ST_MARK
    } state_t;

    typedef enum logic [1:0] { DIV_TB, DIV_D1, DIV_D2 } div_sel_t;
    typedef enum logic [1:0] { OUT_FIRST, OUT_SECOND, OUT_MARK } out_kind_t;

    typedef struct packed {
        logic      load_in;
        logic      restore;
        logic      parse;
        logic      pass2;
        logic      shift_held;
        logic      clear_melody;
        logic      div_start;
        div_sel_t  div_sel;
        logic      out_load;
        out_kind_t out_kind;
    } cmd_t;

    typedef struct packed {
        logic held_valid;
        logic last;
        logic tb_req;
        logic play_req;
        logic two_part;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

// ----- sv/mstt_divider.sv -----
// ----------------------------------------------------------------------------
// mstt_divider
// Restoring divider, 16-bit dividend by 8-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module mstt_divider
    import mstt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic [15:0] quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [7:0]  rem_reg, rem_next;
    logic [15:0] q_reg, q_next;
    logic [7:0]  div_reg, div_next;
    logic [8:0]  trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        div_next  = div_reg;
        trial     = {rem_reg, q_reg[15]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            q_next    = dividend;
            div_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = 8'(trial - {1'b0, div_reg});
                q_next   = {q_reg[14:0], 1'b1};
            end else begin
                rem_next = trial[7:0];
                q_next   = {q_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- sv/mstt_datapath.sv -----
// ----------------------------------------------------------------------------
// mstt_datapath
// Parse state, one-character parse step, duration arithmetic, result register.
// ----------------------------------------------------------------------------
module mstt_datapath
    import mstt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  in_item_t    s_item,
    input  cmd_t        cmd,
    output status_t     status,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item
);

    // Defaults
    logic [7:0] dflt_tempo_reg;
    logic [8:0] dflt_len_reg;
    logic [1:0] dflt_art_reg;
    logic [3:0] dflt_oct_reg;
    logic [4:0] dflt_tr_reg;

    // Input latch
    logic [7:0] in_char_reg;
    logic       in_last_reg;

    // Parse state
    logic [7:0]        held_char_reg;
    logic              held_valid_reg;
    logic [7:0]        tempo_reg, tempo_next;
    logic [10:0]       time_base_reg;
    logic [8:0]        length_code_reg, length_code_next;
    logic [1:0]        art_reg, art_next;
    logic [3:0]        octave_reg, octave_next;
    logic signed [4:0] transpose_reg, transpose_next;
    logic signed [1:0] acc_reg, acc_next;
    logic              dotted_reg, dotted_next;
    logic [7:0]        pending_reg, pending_next;
    logic [13:0]       number_reg, number_next;
    logic [1:0]        digits_reg, digits_next;
    logic              consume_reg, consume_next;
    logic              any_note_reg, any_note_next;

    // Play request
    logic        tb_req_reg, tb_req_next;
    logic        play_req_reg, play_req_next;
    logic [12:0] play_freq_reg, play_freq_next;
    logic [12:0] play_base_reg, play_base_next;
    logic [4:0]  play_den_reg, play_den_next;
    logic [1:0]  play_art_reg, play_art_next;

    // Divider
    logic        div_done;
    logic [15:0] div_q;
    logic [15:0] div_dividend;
    logic [7:0]  div_divisor;
    div_sel_t    div_sel_reg;

    // Result register
    logic      m_valid_reg;
    out_item_t m_item_reg;
    logic      out_free;

    logic [7:0] tempo_dflt_clamped;
    assign tempo_dflt_clamped = (dflt_tempo_reg < TEMPO_MIN) ? TEMPO_MIN : dflt_tempo_reg;

    // One parse step of the held character against its successor
    always_comb begin : parse_step
        logic [7:0]        c, nx, u, f;
        logic              hn, do_nn, do_run, skip;
        logic [13:0]       run_val;
        logic [14:0]       len;
        logic [15:0]       len3;
        ratio_t            rat;
        logic signed [6:0] step, stepw;
        logic signed [2:0] off;
        logic signed [8:0] oe9, idx;
        logic [2:0]        letter;

        c  = held_char_reg;
        nx = in_char_reg;
        hn = !cmd.pass2;
        tempo_next       = tempo_reg;
        length_code_next = length_code_reg;
        art_next         = art_reg;
        octave_next      = octave_reg;
        transpose_next   = transpose_reg;
        acc_next         = acc_reg;
        dotted_next      = dotted_reg;
        pending_next     = pending_reg;
        number_next      = number_reg;
        digits_next      = digits_reg;
        consume_next     = consume_reg;
        any_note_next    = any_note_reg;
        tb_req_next      = 1'b0;
        play_req_next    = 1'b0;
        play_freq_next   = '0;
        play_base_next   = '0;
        play_den_next    = 5'd1;
        play_art_next    = art_reg;
        do_nn   = 1'b0;
        do_run  = 1'b0;
        skip    = 1'b0;
        run_val = '0;
        f       = '0;
        len     = '0;
        len3    = '0;
        rat     = '0;
        step    = '0;
        stepw   = '0;
        off     = '0;
        oe9     = '0;
        idx     = '0;
        letter  = '0;
        u = ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) ? c - CASE_GAP : c;

        if (consume_reg) begin
            consume_next = 1'b0;
            if (is_digit(c)) begin
                number_next = 14'(number_reg * 14'd10) + {10'd0, c[3:0]};
                digits_next = digits_reg + 2'd1;
                do_nn       = 1'b1;
            end
        end else if (c != CH_SPACE) begin
            priority if (u == CH_DOLLAR) begin
                tempo_next       = tempo_dflt_clamped;
                length_code_next = dflt_len_reg;
                art_next         = dflt_art_reg;
                octave_next      = dflt_oct_reg;
                transpose_next   = dflt_tr_reg;
                tb_req_next      = 1'b1;
            end else if (u == CH_LT) begin
                octave_next = (octave_reg <= 4'd1) ? 4'd1 : octave_reg - 4'd1;
            end else if (u == CH_GT) begin
                octave_next = (octave_reg >= 4'd8) ? 4'd8 : octave_reg + 4'd1;
            end else if (u == CH_LBRK) begin
                transpose_next = (transpose_reg <= -5'sd12) ? -5'sd12 : transpose_reg - 5'sd1;
            end else if (u == CH_RBRK) begin
                transpose_next = (transpose_reg >= 5'sd12) ? 5'sd12 : transpose_reg + 5'sd1;
            end else if (((u >= CH_A) && (u <= CH_G)) || u == CH_R || u == CH_HASH
                         || u == CH_MINUS) begin
                if (hn) begin
                    if (is_digit(nx)) skip = 1'b1;
                    priority if (nx == CH_HASH) begin
                        acc_next = 2'sd1;
                        skip     = 1'b1;
                    end else if (nx == CH_MINUS) begin
                        acc_next = -2'sd1;
                        skip     = 1'b1;
                    end else if (nx == CH_DOT) begin
                        dotted_next  = 1'b1;
                        consume_next = 1'b1;
                    end else begin
                    end
                end
                if (u != CH_HASH && u != CH_MINUS) pending_next = u;
                if (pending_next != 8'd0 && !skip) begin
                    do_run  = 1'b1;
                    run_val = '0;
                end
            end else if (u == CH_M) begin
                if (hn) begin
                    priority if (nx == CH_N || nx == CH_N + CASE_GAP) begin
                        art_next = ART_NORMAL;   consume_next = 1'b1;
                    end else if (nx == CH_L || nx == CH_L + CASE_GAP) begin
                        art_next = ART_LEGATO;   consume_next = 1'b1;
                    end else if (nx == CH_S || nx == CH_S + CASE_GAP) begin
                        art_next = ART_STACCATO; consume_next = 1'b1;
                    end else if (nx == CH_U || nx == CH_U + CASE_GAP) begin
                        art_next = ART_MUTE;     consume_next = 1'b1;
                    end else begin
                    end
                end
                pending_next = u;
            end else if (u == CH_L || u == CH_O || u == CH_T) begin
                pending_next = u;
            end else if (is_digit(u)) begin
                number_next = {10'd0, u[3:0]};
                digits_next = '0;
                do_nn       = 1'b1;
            end else begin
            end
        end

        // Number finished or still growing
        if (do_nn) begin
            if (hn && digits_next < 2'd3 && is_digit(nx)) begin
                consume_next = 1'b1;
            end else begin
                if (hn && digits_next < 2'd3 && nx == CH_DOT) dotted_next = 1'b1;
                run_val     = number_next;
                number_next = '0;
                digits_next = '0;
                if (pending_next != 8'd0) do_run = 1'b1;
            end
        end

        // Execute the pending command
        if (do_run) begin
            f            = pending_next;
            pending_next = '0;
            if (((f >= CH_A) && (f <= CH_G)) || f == CH_R) begin
                len = (run_val == 14'd0) ? {6'd0, length_code_next} : {1'b0, run_val};
                if (dotted_next) begin
                    len3 = {len, 1'b0} + {1'b0, len};
                    len  = len3[15:1];
                end
                rat = length_ratio(len);
                play_base_next = 13'(time_base_reg * rat.num);
                play_den_next  = rat.den;
                play_art_next  = art_next;
                if (f != CH_R) begin
                    letter = 3'(f - CH_A);
                    step = $signed({3'b000, LETTER_SEMI[letter]}) + 7'(transpose_next)
                         + 7'(acc_next);
                    priority if (step < -7'sd12) begin
                        stepw = step + 7'sd24;
                        off   = (octave_next > 4'd1) ? -3'sd2 : 3'sd0;
                    end else if (step < 7'sd0) begin
                        stepw = step + 7'sd12;
                        off   = (octave_next > 4'd1) ? -3'sd1 : 3'sd0;
                    end else if (step > 7'sd23) begin
                        stepw = step - 7'sd24;
                        off   = (octave_next < 4'd8) ? 3'sd2 : 3'sd0;
                    end else if (step > 7'sd11) begin
                        stepw = step - 7'sd12;
                        off   = (octave_next < 4'd8) ? 3'sd1 : 3'sd0;
                    end else begin
                        stepw = step;
                        off   = 3'sd0;
                    end
                    oe9 = $signed({5'd0, octave_next}) + 9'(off);
                    idx = (oe9 <<< 3) + (oe9 <<< 2) + 9'(stepw);
                    if (idx >= 9'sd0 && idx <= $signed({2'b00, PITCH_LAST}))
                        play_freq_next = PITCH_HZ[idx[6:0]];
                end
                dotted_next   = 1'b0;
                acc_next      = '0;
                any_note_next = 1'b1;
                play_req_next = 1'b1;
            end else if (f == CH_L) begin
                rat = length_ratio({1'b0, run_val});
                if (rat.num != 3'd0)
                    length_code_next = run_val[8:0];
            end else if (f == CH_O) begin
                octave_next = (run_val < 14'd1) ? 4'd1 :
                              (run_val > 14'd8) ? 4'd8 : run_val[3:0];
            end else if (f == CH_T) begin
                tempo_next  = (run_val < 14'(TEMPO_MIN)) ? TEMPO_MIN :
                              (run_val > 14'd255) ? 8'd255 : run_val[7:0];
                tb_req_next = 1'b1;
            end
        end
    end

    // Divider operand selection
    always_comb begin
        div_dividend = {3'd0, play_base_reg};
        div_divisor  = {3'd0, play_den_reg};
        unique case (cmd.div_sel)
            DIV_TB: begin
                div_dividend = MS_PER_MIN;
                div_divisor  = tempo_reg;
            end
            DIV_D1: begin
                if (play_art_reg == ART_NORMAL) begin
                    div_dividend = {play_base_reg, 3'd0} - {3'd0, play_base_reg};
                    div_divisor  = {play_den_reg, 3'd0};
                end else if (play_art_reg == ART_STACCATO) begin
                    div_dividend = {2'd0, play_base_reg, 1'b0} + {3'd0, play_base_reg};
                    div_divisor  = {1'b0, play_den_reg, 2'd0};
                end
            end
            DIV_D2: begin
                if (play_art_reg == ART_NORMAL) div_divisor = {play_den_reg, 3'd0};
                else                            div_divisor = {1'b0, play_den_reg, 2'd0};
            end
            default: ;
        endcase
    end

    mstt_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Configuration and parse state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dflt_tempo_reg  <= 8'd120;
            dflt_len_reg    <= 9'd4;
            dflt_art_reg    <= ART_NORMAL;
            dflt_oct_reg    <= 4'd4;
            dflt_tr_reg     <= '0;
            held_char_reg   <= '0;
            held_valid_reg  <= 1'b0;
            tempo_reg       <= 8'd120;
            time_base_reg   <= TB_RESET;
            length_code_reg <= 9'd4;
            art_reg         <= ART_NORMAL;
            octave_reg      <= 4'd4;
            transpose_reg   <= '0;
            acc_reg         <= '0;
            dotted_reg      <= 1'b0;
            pending_reg     <= '0;
            number_reg      <= '0;
            digits_reg      <= '0;
            consume_reg     <= 1'b0;
            any_note_reg    <= 1'b0;
            tb_req_reg      <= 1'b0;
            play_req_reg    <= 1'b0;
            div_sel_reg     <= DIV_TB;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_TEMPO:     dflt_tempo_reg <= cfg_data[7:0];
                    CFG_LENGTH:    dflt_len_reg   <= cfg_data;
                    CFG_ARTIC:     dflt_art_reg   <= cfg_data[1:0];
                    CFG_OCTAVE:    dflt_oct_reg   <= cfg_data[3:0];
                    CFG_TRANSPOSE: dflt_tr_reg    <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (cmd.div_start) div_sel_reg <= cmd.div_sel;
            if (div_done && div_sel_reg == DIV_TB) time_base_reg <= div_q[10:0];
            if (cmd.restore) begin
                tempo_reg       <= tempo_dflt_clamped;
                length_code_reg <= dflt_len_reg;
                art_reg         <= dflt_art_reg;
                octave_reg      <= dflt_oct_reg;
                transpose_reg   <= dflt_tr_reg;
            end
            if (cmd.parse) begin
                tempo_reg       <= tempo_next;
                length_code_reg <= length_code_next;
                art_reg         <= art_next;
                octave_reg      <= octave_next;
                transpose_reg   <= transpose_next;
                acc_reg         <= acc_next;
                dotted_reg      <= dotted_next;
                pending_reg     <= pending_next;
                number_reg      <= number_next;
                digits_reg      <= digits_next;
                consume_reg     <= consume_next;
                any_note_reg    <= any_note_next;
                tb_req_reg      <= tb_req_next;
                play_req_reg    <= play_req_next;
            end
            if (cmd.shift_held) begin
                held_char_reg  <= in_char_reg;
                held_valid_reg <= 1'b1;
            end
            if (cmd.clear_melody) begin
                held_char_reg  <= '0;
                held_valid_reg <= 1'b0;
                acc_reg        <= '0;
                dotted_reg     <= 1'b0;
                pending_reg    <= '0;
                number_reg     <= '0;
                digits_reg     <= '0;
                consume_reg    <= 1'b0;
                any_note_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_char_reg <= s_item.char_code;
            in_last_reg <= s_item.last_char;
        end
        if (cmd.parse) begin
            play_freq_reg <= play_freq_next;
            play_base_reg <= play_base_next;
            play_den_reg  <= play_den_next;
            play_art_reg  <= play_art_next;
        end
    end

    // Result register
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_item_reg <= '0;
            unique case (cmd.out_kind)
                OUT_FIRST: begin
                    m_item_reg.frequency_hz <= (play_art_reg == ART_MUTE) ? 13'd0 : play_freq_reg;
                    m_item_reg.duration_ms  <= div_q[12:0];
                end
                OUT_SECOND: m_item_reg.duration_ms <= div_q[12:0];
                OUT_MARK: begin
                    m_item_reg.end_of_melody <= 1'b1;
                    m_item_reg.no_notes      <= !any_note_reg;
                end
                default: ;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    assign status.held_valid = held_valid_reg;
    assign status.last       = in_last_reg;
    assign status.tb_req     = tb_req_reg;
    assign status.play_req   = play_req_reg;
    assign status.two_part   = (play_art_reg == ART_NORMAL) || (play_art_reg == ART_STACCATO);
    assign status.div_done   = div_done;
    assign status.out_free   = out_free;

endmodule

// ----- sv/mstt_ctrl.sv -----
// ----------------------------------------------------------------------------
// mstt_ctrl
// Sequencer: one character item through parse, divisions and result slots.
// ----------------------------------------------------------------------------
module mstt_ctrl
    import mstt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;
    state_t after_st;

    // Where to go once a pass is finished: shift in the new character or mark the end
    assign after_st = phase_reg ? ST_MARK : ST_SHIFT;

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    phase_next = 1'b0;
                    state_next = status.held_valid ? ST_PARSE1 : ST_RESTORE;
                end
            end
            ST_RESTORE:  state_next = ST_TB_GO;
            ST_PARSE1:   state_next = ST_DISPATCH;
            ST_PARSE2: begin
                phase_next = 1'b1;
                state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                priority if (status.tb_req)   state_next = ST_TB_GO;
                else if (status.play_req)     state_next = ST_D1_GO;
                else                          state_next = after_st;
            end
            ST_TB_GO:    state_next = ST_TB_WAIT;
            ST_TB_WAIT:  if (status.div_done) state_next = after_st;
            ST_D1_GO:    state_next = ST_D1_WAIT;
            ST_D1_WAIT:  if (status.div_done) state_next = ST_EMIT1;
            ST_EMIT1: begin
                if (status.out_free) state_next = status.two_part ? ST_D2_GO : after_st;
            end
            ST_D2_GO:    state_next = ST_D2_WAIT;
            ST_D2_WAIT:  if (status.div_done) state_next = ST_EMIT2;
            ST_EMIT2:    if (status.out_free) state_next = after_st;
            ST_SHIFT:    state_next = status.last ? ST_PARSE2 : ST_IDLE;
            ST_MARK:     if (status.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            ST_RESTORE: cmd.restore = 1'b1;
            ST_PARSE1:  cmd.parse   = 1'b1;
            ST_PARSE2: begin
                cmd.parse = 1'b1;
                cmd.pass2 = 1'b1;
            end
            ST_TB_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_TB;
            end
            ST_D1_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_D1;
            end
            ST_D2_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_D2;
            end
            ST_D1_WAIT: cmd.div_sel = DIV_D1;
            ST_D2_WAIT: cmd.div_sel = DIV_D2;
            ST_EMIT1: begin
                cmd.out_load = status.out_free;
                cmd.out_kind = OUT_FIRST;
            end
            ST_EMIT2: begin
                cmd.out_load = status.out_free;
                cmd.out_kind = OUT_SECOND;
            end
            ST_SHIFT: cmd.shift_held = 1'b1;
            ST_MARK: begin
                cmd.out_load     = status.out_free;
                cmd.out_kind     = OUT_MARK;
                cmd.clear_melody = status.out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// ----- sv/melody_string_to_tones_core.sv -----
// One character is taken at a time; each tone or silence item costs one 16-step
// division and a slot in the result register, and a tempo change adds a division.
// A final character also runs a second parse pass and can flush a second note.
// Reset (aresetn low at a clock edge) restores the default registers, empties the
// held character and the result register; no clearing pass is needed.
// ----------------------------------------------------------------------------
// melody_string_to_tones_core
// Melody string parser: characters in, tone/silence items and an end marker out.
// ----------------------------------------------------------------------------
module melody_string_to_tones_core
    import mstt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // Configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [8:0] cfg_data,
    // Character items in
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_item,
    // Tone items out
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_item
);

    cmd_t    cmd;
    status_t status;

    // Configuration writes are always taken; they only touch the default registers.
    assign cfg_ready = 1'b1;

    // Sequencer: hold each character, run the parse passes, start the divider,
    // and drop one item at a time into the result register.
    mstt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath: parse state, note and duration arithmetic, shared divider,
    // result register that parts the sequencer from the downstream side.
    mstt_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_item    (s_item),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

// ----- sv/mstt_checker.sv -----
// ----------------------------------------------------------------------------
// mstt_checker
// Port-level checks of the melody parser, bound to the top level.
// ----------------------------------------------------------------------------
module mstt_checker
    import mstt_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic [2:0] cfg_index,
    input logic [8:0] cfg_data,
    input logic       s_valid,
    input logic       s_ready,
    input in_item_t   s_item,
    input logic       m_valid,
    input logic       m_ready,
    input out_item_t  m_item
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item changed while stalled");

    a_marker_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.end_of_melody |->
            m_item.frequency_hz == 13'd0 && m_item.duration_ms == 13'd0)
        else $error("end marker carries a tone");

    a_tone_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.end_of_melody |-> !m_item.no_notes)
        else $error("no_notes set on a tone item");

    a_freq_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.frequency_hz <= 13'd7902)
        else $error("frequency outside the pitch table");

endmodule

bind melody_string_to_tones_core mstt_checker u_mstt_checker (.*);
